FILE: hdl/cfe_pkg.sv
// Shared types and constants of the Cholesky factor engine.
package cfe_pkg;

	localparam int DefMatrixDim = 4;
	localparam int DataW        = 32;
	localparam int AccW         = 64;
	localparam int DimW         = 3;

	localparam logic [DimW-1:0] RegActiveDimRst = 3'd4;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_RD_A,
		ST_WAIT_A,
		ST_RD_UR,
		ST_RD_UC,
		ST_MUL,
		ST_SUB,
		ST_FIN,
		ST_SQRT,
		ST_DIV,
		ST_WR,
		ST_ORD,
		ST_OCAP,
		ST_OHOLD
	} cfe_state_t;

	// Start and completion of an iterative unit
	typedef struct packed {
		logic start;
	} cfe_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cfe_rsp_t;

endpackage

FILE: hdl/cfe_sqrt.sv
// Iterative floor square root of a 64-bit value, one result bit per cycle.
module cfe_sqrt import cfe_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cfe_req_t            req,
	input  logic [AccW-1:0]     radicand,
	output cfe_rsp_t            rsp,
	output logic [AccW/2-1:0]   root
);
	localparam int Steps = AccW / 2;
	localparam int CntW  = $clog2(Steps + 1);
	localparam int RemW  = AccW / 2 + 3;

	logic [AccW-1:0]   x_q;
	logic [AccW/2-1:0] root_q;
	logic [RemW-1:0]   rem_q;
	logic [CntW-1:0]   cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [RemW-1:0]   rem_sh;
	logic [RemW-1:0]   trial;

	// Bring down two bits and try the next root bit
	always_comb begin
		rem_sh = {rem_q[RemW-3:0], x_q[AccW-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(Steps);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Payload of the root iteration
	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q    <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[AccW-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[AccW/2-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[AccW/2-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign root     = root_q;

endmodule

FILE: hdl/cfe_div.sv
// Iterative restoring divider: 64-bit magnitude by 32-bit divisor, one bit per cycle.
module cfe_div import cfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfe_req_t          req,
	input  logic [AccW-1:0]   dividend,
	input  logic [DataW-1:0]  divisor,
	output cfe_rsp_t          rsp,
	output logic [AccW-1:0]   quotient
);
	localparam int CntW = $clog2(AccW + 1);

	logic [AccW-1:0]  q_q;
	logic [DataW:0]   rem_q;
	logic [DataW-1:0] d_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DataW:0]   rem_sh;

	assign rem_sh = {rem_q[DataW-1:0], q_q[AccW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(AccW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift in one dividend bit and subtract where it fits
	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q   <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			if (rem_sh >= {1'b0, d_q}) begin
				rem_q <= rem_sh - {1'b0, d_q};
				q_q   <= {q_q[AccW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				q_q   <= {q_q[AccW-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign quotient = q_q;

endmodule

FILE: hdl/cholesky_factor_engine_core.sv
// Top level of the Cholesky factor engine: load memory, factor memory and sequencer.
// Sequence: after the last element, each factor entry in row r and column c>=r is formed by
// a multiply-accumulate over the rows above it, then a square root on the diagonal or a divide off it.
// Output: each factor word is read from the factor memory, captured (ORD, OCAP) and held until accepted.
// Throughput: one matrix at a time; no element is taken until all words are delivered.
// Reset: asynchronous, active low; active_dim returns to 4, load count and flag clear.
module cholesky_factor_engine_core import cfe_pkg::*; #(
	parameter int MATRIX_DIM = DefMatrixDim
) (
	input  logic             clk,
	input  logic             arst_n,
	// APB configuration
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// input stream
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // [31:0] element_value
	// output stream
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata,   // [31:0] factor_value
	output logic             m_tlast,
	output logic [0:0]       m_tuser    // [0] not_positive
);
	localparam int Cells = MATRIX_DIM * MATRIX_DIM;
	localparam int AW    = (Cells > 1) ? $clog2(Cells) : 1;
	localparam int CW    = $clog2(Cells + 1);
	localparam int RW    = $clog2(MATRIX_DIM + 1);
	localparam int IW    = 2 * RW + 1;

	logic signed [DataW-1:0] amem [Cells];
	logic signed [DataW-1:0] umem [Cells];

	cfe_state_t state_q, state_d;

	logic [DimW-1:0]   dim_q;
	logic [CW-1:0]     load_q;
	logic [RW-1:0]     n;
	logic [CW-1:0]     total;
	logic [RW-1:0]     r_q, c_q, k_q;
	logic              bad_q, err_q;
	logic [DataW-1:0]  diag_q;
	logic signed [AccW-1:0] acc_q;
	logic signed [DataW-1:0] ur_q;
	logic signed [AccW-1:0] prod_s1;
	logic signed [DataW-1:0] a_rd_q, u_rd_q;
	logic [DataW-1:0]  out_q;
	logic              last_q;
	logic [AW-1:0]     u_raddr;
	logic [IW-1:0]     a_idx, u_idx;
	logic              cfg_wr;
	logic              in_acc, out_acc;
	logic [AccW:0]     diff;
	logic signed [AccW-1:0] acc_sub;
	logic [AccW-1:0]   acc_mag;
	logic [DataW-1:0]  wr_val, div_val;
	cfe_req_t          sq_req, dv_req;
	cfe_rsp_t          sq_rsp, dv_rsp;
	logic [AccW/2-1:0] sq_root;
	logic [AccW-1:0]   dv_quot;

	// Clamp the dimension in use
	always_comb begin
		if (dim_q == '0)
			n = RW'(1);
		else if (32'(dim_q) > 32'(MATRIX_DIM))
			n = RW'(MATRIX_DIM);
		else
			n = RW'(dim_q);
		total = CW'(n * n);
	end

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? {29'd0, dim_q} : 32'd0;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// Load memory
	always_ff @(posedge clk) begin
		if (in_acc)
			amem[(load_q >= total) ? AW'(0) : load_q[AW-1:0]] <= s_tdata;
		a_rd_q <= amem[a_idx[AW-1:0]];
	end

	// Factor memory
	always_ff @(posedge clk) begin
		if (state_q == ST_WR)
			umem[AW'(32'(r_q) * MATRIX_DIM + 32'(c_q))] <= wr_val;
		u_rd_q <= umem[u_raddr];
	end

	assign a_idx = IW'(r_q * n + IW'(c_q));

	always_comb begin
		unique case (state_q)
			ST_RD_UR: u_idx = IW'(32'(k_q) * MATRIX_DIM + 32'(r_q));
			ST_RD_UC: u_idx = IW'(32'(k_q) * MATRIX_DIM + 32'(c_q));
			default:  u_idx = IW'(32'(r_q) * MATRIX_DIM + 32'(c_q));
		endcase
		u_raddr = u_idx[AW-1:0];
	end

	// Saturating subtract of the product
	always_comb begin
		diff = {acc_q[AccW-1], acc_q} - {prod_s1[AccW-1], prod_s1};
		if (diff[AccW] != diff[AccW-1])
			acc_sub = diff[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
		else
			acc_sub = diff[AccW-1:0];
		acc_mag = acc_q[AccW-1] ? (~acc_q + 1'b1) : acc_q;
	end

	// Sign and saturate the quotient
	always_comb begin
		if (acc_q[AccW-1]) begin
			if (dv_quot > AccW'(64'h8000_0000))
				div_val = 32'h8000_0000;
			else
				div_val = DataW'(~dv_quot + 1'b1);
		end else begin
			if (dv_quot > AccW'(64'h7FFF_FFFF))
				div_val = 32'h7FFF_FFFF;
			else
				div_val = dv_quot[DataW-1:0];
		end
	end

	cfe_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .req(sq_req),
		.radicand(acc_q), .rsp(sq_rsp), .root(sq_root)
	);

	cfe_div u_div (
		.clk(clk), .arst_n(arst_n), .req(dv_req), .dividend(acc_mag),
		.divisor(diag_q), .rsp(dv_rsp), .quotient(dv_quot)
	);

	// Next state
	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		sq_req.start = 1'b0;
		dv_req.start = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				if (in_acc && ((load_q >= total) ? (total == CW'(1)) :
				    (load_q + 1'b1 == total)))
					state_d = ST_RD_A;
			end
			ST_RD_A:   state_d = ST_WAIT_A;
			ST_WAIT_A: state_d = (r_q == '0) ? ST_FIN : ST_RD_UR;
			ST_RD_UR:  state_d = ST_RD_UC;
			ST_RD_UC:  state_d = ST_MUL;
			ST_MUL:    state_d = ST_SUB;
			ST_SUB:    state_d = (k_q + 1'b1 == r_q) ? ST_FIN : ST_RD_UR;
			ST_FIN: begin
				if (c_q == r_q) begin
					if (acc_q[AccW-1] || acc_q == '0)
						state_d = ST_WR;
					else begin
						sq_req.start = 1'b1;
						state_d      = ST_SQRT;
					end
				end else if (bad_q)
					state_d = ST_WR;
				else begin
					dv_req.start = 1'b1;
					state_d      = ST_DIV;
				end
			end
			ST_SQRT: if (sq_rsp.done) state_d = ST_WR;
			ST_DIV:  if (dv_rsp.done) state_d = ST_WR;
			ST_WR: begin
				if (c_q + 1'b1 == n && r_q + 1'b1 == n)
					state_d = ST_ORD;
				else
					state_d = ST_RD_A;
			end
			ST_ORD:  state_d = ST_OCAP;
			ST_OCAP: state_d = ST_OHOLD;
			ST_OHOLD: begin
				if (out_acc)
					state_d = last_q ? ST_LOAD : ST_ORD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// Value written to the factor memory
	always_comb begin
		if (c_q == r_q) begin
			if (acc_q[AccW-1] || acc_q == '0)
				wr_val = '0;
			else if (sq_root[AccW/2-1])
				wr_val = 32'h7FFF_FFFF;
			else
				wr_val = sq_root;
		end else if (bad_q)
			wr_val = '0;
		else
			wr_val = div_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_LOAD;
		else
			state_q <= state_d;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q    <= RegActiveDimRst;
			load_q   <= '0;
			r_q      <= '0;
			c_q      <= '0;
			k_q      <= '0;
			bad_q    <= 1'b0;
			err_q    <= 1'b0;
			m_tvalid <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				dim_q  <= pwdata[DimW-1:0];
				load_q <= '0;
			end else if (in_acc) begin
				if (state_d == ST_RD_A)
					load_q <= '0;
				else if (load_q >= total)
					load_q <= CW'(1);
				else
					load_q <= load_q + 1'b1;
			end
			unique case (state_q)
				ST_LOAD: begin
					r_q   <= '0;
					c_q   <= '0;
					bad_q <= 1'b0;
					if (state_d == ST_RD_A)
						err_q <= 1'b0;
				end
				ST_WAIT_A: k_q <= '0;
				ST_SUB:    k_q <= k_q + 1'b1;
				ST_FIN: begin
					if (c_q == r_q && (acc_q[AccW-1] || acc_q == '0)) begin
						bad_q <= 1'b1;
						err_q <= 1'b1;
					end
				end
				ST_WR: begin
					if (c_q + 1'b1 == n) begin
						if (r_q + 1'b1 == n) begin
							r_q <= '0;
							c_q <= '0;
						end else begin
							r_q <= r_q + 1'b1;
							c_q <= r_q + 1'b1;
						end
						bad_q <= 1'b0;
					end else
						c_q <= c_q + 1'b1;
				end
				ST_OCAP: begin
					m_tvalid <= 1'b1;
					last_q   <= (r_q + 1'b1 == n) && (c_q + 1'b1 == n);
				end
				ST_OHOLD: begin
					if (out_acc) begin
						m_tvalid <= 1'b0;
						if (c_q + 1'b1 == n) begin
							c_q <= '0;
							r_q <= r_q + 1'b1;
						end else
							c_q <= c_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_WAIT_A: acc_q <= {{(AccW-DataW-16){a_rd_q[DataW-1]}}, a_rd_q, 16'd0};
			ST_RD_UC:  ur_q  <= u_rd_q;
			ST_SUB:    acc_q <= acc_sub;
			ST_WR:     if (c_q == r_q) diag_q <= wr_val;
			ST_OCAP:   out_q <= (c_q >= r_q) ? u_rd_q : '0;
			default: ;
		endcase
		if (state_q == ST_MUL)
			prod_s1 <= AccW'(ur_q * u_rd_q);
	end

	assign m_tdata    = out_q;
	assign m_tlast    = last_q;
	assign m_tuser[0] = err_q;

endmodule

FILE: test/cholesky_factor_engine_core_test.sv
// Testbench of the Cholesky factor engine: random and directed matrices checked against a predictor.
module cholesky_factor_engine_core_test;
	import cfe_pkg::*;

	localparam int Dim = DefMatrixDim;
	localparam logic [2:0] AddrActiveDim = 3'd0;
	localparam logic [2:0] AddrUnused = 3'd4;
	localparam int IdleLimit = 20000;

	typedef struct packed {
		logic [31:0] factor_value;
		logic        is_last;
		logic        not_positive;
	} factor_word_t;

	// Factor prediction and result scoreboard
	class factor_board;
		logic [2:0]  dim_reg;
		logic [31:0] elems[Dim*Dim];
		int          loaded;
		factor_word_t pending[$];
		int          errors;

		function new();
			dim_reg = RegActiveDimRst;
			loaded = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] addr, logic [31:0] data);
			if (addr == AddrActiveDim) begin
				dim_reg = data[2:0];
				loaded = 0;
			end
		endfunction

		function int dim_now();
			int n;
			n = dim_reg;
			if (n < 1) n = 1;
			if (n > Dim) n = Dim;
			return n;
		endfunction

		function longint sub_sat(longint a, longint p);
			longint d;
			d = a - p;
			if (p > 0 && d > a) return 64'sh8000000000000000;
			if (p < 0 && d < a) return 64'sh7fffffffffffffff;
			return d;
		endfunction

		function logic [63:0] root64(logic [63:0] x);
			logic [63:0] res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > x) b = b >> 2;
			while (b != 0) begin
				if (x >= res + b) begin
					x = x - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function void factorize(int n);
			int signed u[Dim][Dim];
			longint acc, q;
			logic bad, flag;
			logic [63:0] s;
			factor_word_t w;
			flag = 0;
			for (int r = 0; r < Dim; r++)
				for (int c = 0; c < Dim; c++) u[r][c] = 0;
			for (int r = 0; r < n; r++) begin
				bad = 0;
				for (int c = r; c < n; c++) begin
					acc = longint'($signed(elems[r*n+c])) * 65536;
					for (int k = 0; k < r; k++)
						acc = sub_sat(acc, longint'(u[k][r]) * longint'(u[k][c]));
					if (c == r) begin
						if (acc <= 0) begin
							bad = 1;
							flag = 1;
							u[r][c] = 0;
						end else begin
							s = root64(acc);
							u[r][c] = (s > 64'h7fffffff) ? 32'h7fffffff : s[31:0];
						end
					end else if (bad) begin
						u[r][c] = 0;
					end else begin
						q = acc / longint'(u[r][r]);
						if (q > 64'sh7fffffff) u[r][c] = 32'h7fffffff;
						else if (q < -64'sh80000000) u[r][c] = 32'h80000000;
						else u[r][c] = q[31:0];
					end
				end
			end
			for (int r = 0; r < n; r++)
				for (int c = 0; c < n; c++) begin
					w.factor_value = (c >= r) ? u[r][c] : 32'd0;
					w.is_last = (r == n-1) && (c == n-1);
					w.not_positive = flag;
					pending.push_back(w);
				end
		endfunction

		function void note_element(logic [31:0] v);
			int n;
			n = dim_now();
			if (loaded >= n*n) loaded = 0;
			elems[loaded] = v;
			loaded++;
			if (loaded == n*n) begin
				loaded = 0;
				factorize(n);
			end
		endfunction

		function void check_word(logic [31:0] v, logic last, logic np);
			factor_word_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word %h last %b flag %b", $time, v, last, np);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (e.factor_value !== v) begin
				$display("%0t: factor_value expected %h actual %h", $time, e.factor_value, v);
				errors++;
			end
			if (e.is_last !== last) begin
				$display("%0t: is_last expected %b actual %b", $time, e.is_last, last);
				errors++;
			end
			if (e.not_positive !== np) begin
				$display("%0t: not_positive expected %b actual %b", $time, e.not_positive, np);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic s_tvalid, s_tready, m_tvalid, m_tready, m_tlast;
	logic [31:0] s_tdata, m_tdata;
	logic [0:0] m_tuser;

	factor_board board;
	bit quiet;
	int idle_cycles;
	int stall_left = 0;

	cholesky_factor_engine_core dut (.*);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// Check each accepted result word and stall the receiver in bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) board.check_word(m_tdata, m_tlast, m_tuser[0]);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				stall_left = $urandom_range(0, 5);
			end else
				m_tready <= 1'b1;
		end
	end

	// Watchdog on cycles with no accepted word or register access
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		s_tvalid <= 1'b0;
		psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		board.write_reg(addr, data);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// Send one element, with an occasional random idle burst ahead of it
	task automatic send_element(logic [31:0] v);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		do @(posedge clk); while (!s_tready);
		board.note_element(v);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return $urandom_range(0, 8) << 16;
			2: return 32'h80000000 | $urandom_range(0, 3);
			3: return 32'h7fffffff - $urandom_range(0, 3);
			default: return ($urandom() & 32'h0003ffff) - 32'h00020000;
		endcase
	endfunction

	// Symmetric, mostly diagonally dominant matrix of size n
	task automatic send_matrix(int n, int shape);
		logic [31:0] m[Dim][Dim];
		for (int r = 0; r < n; r++)
			for (int c = r; c < n; c++) begin
				if (shape == 0) m[r][c] = rand_elem();
				else if (r == c) m[r][c] = $urandom_range(1 << 18, 1 << 22);
				else m[r][c] = $urandom_range(0, 1 << 17) - (1 << 16);
				m[c][r] = m[r][c];
			end
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++) send_element(m[r][c]);
	endtask

	initial begin
		int n, count;
		board = new();
		quiet = 0;
		arst_n = 1'b0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		s_tvalid = 0; s_tdata = 0; m_tready = 0;
		idle_cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset size, extremes, clamped sizes, non-positive pivot
		send_element(32'h80000000);
		send_element(32'h7fffffff);
		for (int i = 0; i < 14; i++) send_element(i[0] ? 32'hffffffff : 32'h00010000);
		drain();
		reg_write(AddrActiveDim, 32'd0);
		send_element(32'h7fffffff);
		send_element(32'h00000000);
		drain();
		reg_write(AddrActiveDim, 32'd1);
		send_element(32'hffff0000);
		drain();
		reg_write(AddrActiveDim, 32'd2);
		send_element(32'h00040000); send_element(32'h00010000);
		reg_write(AddrActiveDim, 32'hfffffff2);
		send_element(32'h00040000); send_element(32'h00010000);
		send_element(32'h00010000); send_element(32'h00000000);
		drain();
		reg_write(AddrUnused, 32'd1);
		reg_write(AddrActiveDim, 32'd7);
		send_matrix(4, 1);
		drain();

		// Random phases over several sizes
		count = 0;
		while (count < 250) begin
			n = $urandom_range(1, 7);
			reg_write(AddrActiveDim, n | ($urandom() & 32'hfffffff8));
			n = board.dim_now();
			quiet = (count > 200);
			repeat ($urandom_range(1, 3)) begin
				send_matrix(n, ($urandom_range(0, 3) == 0) ? 0 : 1);
				count += n * n;
			end
			if ($urandom_range(0, 3) == 0) send_element(rand_elem());
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
